// File: sv/csfc_pkg.sv
// ----------------------------------------------------------------------------
// csfc_pkg
// Shared constants, widths and sequencer states of the capped spanning forest
// cost block.
// ----------------------------------------------------------------------------
package csfc_pkg;

  localparam int MaxNodes  = 1024;
  localparam int MaxEdges  = 4096;

  localparam int NodeW     = $clog2(MaxNodes);      // 0-based node index
  localparam int CountW    = 11;                    // node_count, component_total
  localparam int WeightW   = 32;
  localparam int CostW     = 43;
  localparam int EdgeAddrW = $clog2(MaxEdges);
  localparam int FillW     = $clog2(MaxEdges + 1);
  localparam int KeyW      = WeightW + 2 * NodeW;   // {weight, a-1, b-1}

  localparam int InDataW   = 56;
  localparam int OutDataW  = 56;

  localparam logic CfgNodeCount = 1'b0;
  localparam logic CfgFixedCost = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLR,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_EVAL,
    ST_FIND_RD,
    ST_FIND_CMP,
    ST_MERGE,
    ST_MUL,
    ST_ADD,
    ST_OUT
  } state_e;

endpackage

// File: sv/capped_spanning_forest_cost.sv
// ----------------------------------------------------------------------------
// capped_spanning_forest_cost
// Stores capped edges, then runs Kruskal over them with a union-find table.
// ----------------------------------------------------------------------------
// Usage: configure node_count (index 0) and fixed_node_cost (index 1) through
// the write port while idle. Edge beats enter on the s_axis side, one per
// cycle while the block is idle; an edge heavier than fixed_node_cost is
// ignored, a bad endpoint or a full store sets the dropped flag. A beat with
// tlast starts the finish: a clear pass sets the parent table to identity,
// then each Kruskal step scans every stored edge, a read and a compare per
// edge, to select the next larger key, and walks the parent table hop by
// hop for each endpoint. Each selected edge is evaluated and, if the count
// covers it, merged; the result is formed by a multiply and then an add.
// s_axis_tready is low after the tlast beat until the result beat is taken
// on m_axis; the result is held while the receiver stalls. Reset restores
// node_count = 1, fixed_node_cost = 0, an empty store.
// ----------------------------------------------------------------------------
module capped_spanning_forest_cost (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [31:0]                   cfg_data_i,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // end_a[10:0], end_b[21:11], edge_weight[53:22], zero pad
  input  logic [csfc_pkg::InDataW-1:0]  s_axis_tdata_i,
  // edge_present
  input  logic                          s_axis_tuser_i,
  input  logic                          s_axis_tlast_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // total_cost[42:0], component_total[53:43], zero pad
  output logic [csfc_pkg::OutDataW-1:0] m_axis_tdata_o,
  // dropped_flag
  output logic                          m_axis_tuser_o
);

  localparam int NodeW  = csfc_pkg::NodeW;
  localparam int CountW = csfc_pkg::CountW;
  localparam int KeyW   = csfc_pkg::KeyW;
  localparam int FillW  = csfc_pkg::FillW;
  localparam int EaW    = csfc_pkg::EdgeAddrW;
  localparam int WW     = csfc_pkg::WeightW;
  localparam int CostW  = csfc_pkg::CostW;

  csfc_pkg::state_e state_q, state_d;

  logic [CountW-1:0] node_cnt_q, node_cnt_d;
  logic [WW-1:0]     fixed_q, fixed_d;
  logic [FillW-1:0]  fill_q, fill_d;
  logic              drop_q, drop_d;
  logic [NodeW:0]    clr_idx_q, clr_idx_d;
  logic [FillW-1:0]  scan_idx_q, scan_idx_d;
  logic [KeyW-1:0]   last_key_q, last_key_d;
  logic              have_last_q, have_last_d;
  logic [KeyW-1:0]   best_q, best_d;
  logic              found_q, found_d;
  logic [NodeW-1:0]  node_q, node_d;
  logic              sel_b_q, sel_b_d;
  logic [NodeW-1:0]  ra_q, ra_d;
  logic [NodeW-1:0]  rb_q, rb_d;
  logic [CountW-1:0] set_cnt_q, set_cnt_d;
  logic [CostW-1:0]  sum_q, sum_d;
  logic [CostW-1:0]  prod_q, prod_d;
  logic [CostW-1:0]  total_q, total_d;

  logic [CountW-1:0] n_eff;
  logic [CountW-1:0] in_a, in_b;
  logic [WW-1:0]     in_w;
  logic              in_fire, out_fire;
  logic              bad_end;

  logic              e_we;
  logic [EaW-1:0]    e_waddr, e_raddr;
  logic [KeyW-1:0]   e_wdata, e_rdata;
  logic              p_we;
  logic [NodeW-1:0]  p_waddr, p_wdata, p_rdata;

  logic [NodeW-1:0]  best_a, best_b;
  logic              cand, found_nx;

  assign n_eff = (node_cnt_q > CountW'(csfc_pkg::MaxNodes)) ?
                 CountW'(csfc_pkg::MaxNodes) : node_cnt_q;
  assign in_a = s_axis_tdata_i[CountW-1:0];
  assign in_b = s_axis_tdata_i[2*CountW-1:CountW];
  assign in_w = s_axis_tdata_i[2*CountW+WW-1:2*CountW];

  assign s_axis_tready_o = (state_q == csfc_pkg::ST_IDLE);
  assign m_axis_tvalid_o = (state_q == csfc_pkg::ST_OUT);
  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_fire = m_axis_tvalid_o && m_axis_tready_i;
  assign m_axis_tdata_o = {{(csfc_pkg::OutDataW - CostW - CountW){1'b0}}, set_cnt_q, total_q};
  assign m_axis_tuser_o = drop_q;

  assign bad_end = (in_a == '0) || (in_b == '0) || (in_a > n_eff) || (in_b > n_eff);

  assign best_a = best_q[2*NodeW-1:NodeW];
  assign best_b = best_q[NodeW-1:0];

  assign cand = (!have_last_q || (e_rdata > last_key_q)) && (!found_q || (e_rdata < best_q));
  assign found_nx = found_q || cand;

  assign e_we    = in_fire && s_axis_tuser_i && (in_w <= fixed_q) && !bad_end &&
                   (fill_q < FillW'(csfc_pkg::MaxEdges));
  assign e_waddr = fill_q[EaW-1:0];
  assign e_wdata = {in_w, NodeW'(in_a - CountW'(1)), NodeW'(in_b - CountW'(1))};
  assign e_raddr = scan_idx_q[EaW-1:0];

  csfc_ram #(.Width(KeyW), .Depth(csfc_pkg::MaxEdges)) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (e_we),
    .waddr_i (e_waddr),
    .wdata_i (e_wdata),
    .raddr_i (e_raddr),
    .rdata_o (e_rdata)
  );

  always_comb begin
    p_we    = 1'b0;
    p_waddr = clr_idx_q[NodeW-1:0];
    p_wdata = clr_idx_q[NodeW-1:0];
    if (state_q == csfc_pkg::ST_CLR) begin
      p_we = 1'b1;
    end else if ((state_q == csfc_pkg::ST_MERGE) && (ra_q != rb_q)) begin
      p_we    = 1'b1;
      p_waddr = (ra_q < rb_q) ? rb_q : ra_q;
      p_wdata = (ra_q < rb_q) ? ra_q : rb_q;
    end
  end

  csfc_ram #(.Width(NodeW), .Depth(csfc_pkg::MaxNodes)) u_parent_ram (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (p_waddr),
    .wdata_i (p_wdata),
    .raddr_i (node_q),
    .rdata_o (p_rdata)
  );

  always_comb begin
    state_d     = state_q;
    node_cnt_d  = node_cnt_q;
    fixed_d     = fixed_q;
    fill_d      = fill_q;
    drop_d      = drop_q;
    clr_idx_d   = clr_idx_q;
    scan_idx_d  = scan_idx_q;
    last_key_d  = last_key_q;
    have_last_d = have_last_q;
    best_d      = best_q;
    found_d     = found_q;
    node_d      = node_q;
    sel_b_d     = sel_b_q;
    ra_d        = ra_q;
    rb_d        = rb_q;
    set_cnt_d   = set_cnt_q;
    sum_d       = sum_q;
    prod_d      = prod_q;
    total_d     = total_q;

    if (cfg_we_i) begin
      if (cfg_idx_i == csfc_pkg::CfgNodeCount) begin
        node_cnt_d = cfg_data_i[CountW-1:0];
      end else begin
        fixed_d = cfg_data_i;
      end
    end

    case (state_q)
      csfc_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (s_axis_tuser_i && (in_w <= fixed_q)) begin
            if (bad_end || (fill_q >= FillW'(csfc_pkg::MaxEdges))) begin
              drop_d = 1'b1;
            end else begin
              fill_d = fill_q + FillW'(1);
            end
          end
          if (s_axis_tlast_i) begin
            clr_idx_d = '0;
            state_d   = csfc_pkg::ST_CLR;
          end
        end
      end
      csfc_pkg::ST_CLR: begin
        clr_idx_d = clr_idx_q + (NodeW+1)'(1);
        if (clr_idx_q == (NodeW+1)'(csfc_pkg::MaxNodes - 1)) begin
          set_cnt_d   = n_eff;
          sum_d       = '0;
          have_last_d = 1'b0;
          found_d     = 1'b0;
          scan_idx_d  = '0;
          state_d     = (fill_q == '0) ? csfc_pkg::ST_MUL : csfc_pkg::ST_SCAN_RD;
        end
      end
      csfc_pkg::ST_SCAN_RD: begin
        state_d = csfc_pkg::ST_SCAN_CMP;
      end
      csfc_pkg::ST_SCAN_CMP: begin
        if (cand) begin
          best_d  = e_rdata;
          found_d = 1'b1;
        end
        scan_idx_d = scan_idx_q + FillW'(1);
        state_d    = csfc_pkg::ST_SCAN_RD;
        if (scan_idx_q == fill_q - FillW'(1)) begin
          state_d = found_nx ? csfc_pkg::ST_EVAL : csfc_pkg::ST_MUL;
        end
      end
      csfc_pkg::ST_EVAL: begin
        // skip an edge that the count no longer covers
        if ((CountW'(best_a) >= n_eff) || (CountW'(best_b) >= n_eff)) begin
          last_key_d  = best_q;
          have_last_d = 1'b1;
          found_d     = 1'b0;
          scan_idx_d  = '0;
          state_d     = csfc_pkg::ST_SCAN_RD;
        end else begin
          node_d  = best_a;
          sel_b_d = 1'b0;
          state_d = csfc_pkg::ST_FIND_RD;
        end
      end
      csfc_pkg::ST_FIND_RD: begin
        state_d = csfc_pkg::ST_FIND_CMP;
      end
      csfc_pkg::ST_FIND_CMP: begin
        state_d = csfc_pkg::ST_FIND_RD;
        if (p_rdata == node_q) begin
          if (!sel_b_q) begin
            ra_d    = node_q;
            node_d  = best_b;
            sel_b_d = 1'b1;
          end else begin
            rb_d    = node_q;
            state_d = csfc_pkg::ST_MERGE;
          end
        end else begin
          node_d = p_rdata;
        end
      end
      csfc_pkg::ST_MERGE: begin
        if (ra_q != rb_q) begin
          set_cnt_d = set_cnt_q - CountW'(1);
          sum_d     = sum_q + CostW'(best_q[KeyW-1:2*NodeW]);
        end
        last_key_d  = best_q;
        have_last_d = 1'b1;
        found_d     = 1'b0;
        scan_idx_d  = '0;
        state_d     = csfc_pkg::ST_SCAN_RD;
      end
      csfc_pkg::ST_MUL: begin
        prod_d  = CostW'(set_cnt_q) * CostW'(fixed_q);
        state_d = csfc_pkg::ST_ADD;
      end
      csfc_pkg::ST_ADD: begin
        total_d = sum_q + prod_q;
        state_d = csfc_pkg::ST_OUT;
      end
      csfc_pkg::ST_OUT: begin
        // hold the result beat until taken, then clear the job
        if (out_fire) begin
          fill_d  = '0;
          drop_d  = 1'b0;
          state_d = csfc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = csfc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= csfc_pkg::ST_IDLE;
      node_cnt_q <= CountW'(1);
      fixed_q    <= '0;
      fill_q     <= '0;
      drop_q     <= 1'b0;
      clr_idx_q  <= '0;
      scan_idx_q <= '0;
      have_last_q <= 1'b0;
      found_q    <= 1'b0;
      sel_b_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      node_cnt_q <= node_cnt_d;
      fixed_q    <= fixed_d;
      fill_q     <= fill_d;
      drop_q     <= drop_d;
      clr_idx_q  <= clr_idx_d;
      scan_idx_q <= scan_idx_d;
      have_last_q <= have_last_d;
      found_q    <= found_d;
      sel_b_q    <= sel_b_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last_key_q <= last_key_d;
    best_q     <= best_d;
    node_q     <= node_d;
    ra_q       <= ra_d;
    rb_q       <= rb_d;
    set_cnt_q  <= set_cnt_d;
    sum_q      <= sum_d;
    prod_q     <= prod_d;
    total_q    <= total_d;
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(csfc_pkg::MaxEdges))
    else $error("edge fill beyond store depth");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o))
    else $error("input taken while result pending");

  a_out_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire |=> (fill_q == '0) && !drop_q && s_axis_tready_o)
    else $error("job state not cleared after result");

  a_set_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (set_cnt_q <= n_eff))
    else $error("component count above node count");

endmodule

// File: sv/csfc_ram.sv
// ----------------------------------------------------------------------------
// csfc_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module csfc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for capped_spanning_forest_cost. Edge beats go in on the
// s_axis side and the forest cost results are checked on m_axis. A behavioral
// Kruskal predictor computes the expected totals. Runs cover directed corner
// jobs, random jobs under several idle/stall mixes, and a long sink hold-off.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [csfc_pkg::WeightW-1:0] w;
    logic [csfc_pkg::CountW-1:0]  a;
    logic [csfc_pkg::CountW-1:0]  b;
  } edge_t;

  typedef struct {
    logic [csfc_pkg::CostW-1:0]  cost;
    logic [csfc_pkg::CountW-1:0] comps;
    logic                        dropped;
  } forest_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_we_i = 1'b0;
  logic                          cfg_idx_i = csfc_pkg::CfgNodeCount;
  logic [31:0]                   cfg_data_i = '0;
  logic                          s_axis_tvalid_i = 1'b0;
  logic                          s_axis_tready_o;
  logic [csfc_pkg::InDataW-1:0]  s_axis_tdata_i = '0;
  logic                          s_axis_tuser_i = 1'b0;
  logic                          s_axis_tlast_i = 1'b0;
  logic                          m_axis_tvalid_o;
  logic                          m_axis_tready_i = 1'b0;
  logic [csfc_pkg::OutDataW-1:0] m_axis_tdata_o;
  logic                          m_axis_tuser_o;

  capped_spanning_forest_cost u_top (.*);

  always #1 clk_i = ~clk_i;

  // predictor state
  logic [csfc_pkg::CountW-1:0]  node_cnt = 1;
  logic [csfc_pkg::WeightW-1:0] node_cost = 0;
  edge_t                        kept_edges[$];
  logic                         drop_pending = 1'b0;
  forest_t                      pending_totals[$];

  int errors = 0;
  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  int hold_cycles = 0;

  function automatic int eff_nodes();
    return (node_cnt > csfc_pkg::MaxNodes) ? csfc_pkg::MaxNodes : int'(node_cnt);
  endfunction

  function automatic void predict_forest(logic present, logic [csfc_pkg::CountW-1:0] a,
                                         logic [csfc_pkg::CountW-1:0] b,
                                         logic [csfc_pkg::WeightW-1:0] w, logic last);
    int n;
    int par[csfc_pkg::MaxNodes];
    int sets;
    int ra;
    int rb;
    logic [csfc_pkg::CostW-1:0] sum;
    edge_t e;
    forest_t r;
    n = eff_nodes();
    if (present && w <= node_cost) begin
      if (a == 0 || b == 0 || a > n || b > n || kept_edges.size() >= csfc_pkg::MaxEdges)
        drop_pending = 1'b1;
      else begin
        e.w = w; e.a = a; e.b = b;
        kept_edges.insert(kept_edges.size(), e);
      end
    end
    if (last) begin
      kept_edges.sort() with ({item.w, item.a, item.b});
      for (int i = 0; i < csfc_pkg::MaxNodes; i++) par[i] = i;
      sets = n;
      sum = '0;
      foreach (kept_edges[i]) begin
        // skip edges whose endpoint lies beyond a shrunk node count
        if (kept_edges[i].a > n || kept_edges[i].b > n) continue;
        ra = kept_edges[i].a - 1;
        rb = kept_edges[i].b - 1;
        while (par[ra] != ra) ra = par[ra];
        while (par[rb] != rb) rb = par[rb];
        if (ra == rb) continue;
        if (ra < rb) par[rb] = ra;
        else par[ra] = rb;
        sets--;
        sum = sum + kept_edges[i].w;
      end
      r.cost = sum + csfc_pkg::CostW'(sets) * csfc_pkg::CostW'(node_cost);
      r.comps = csfc_pkg::CountW'(sets);
      r.dropped = drop_pending;
      pending_totals.insert(pending_totals.size(), r);
      kept_edges.delete();
      drop_pending = 1'b0;
    end
  endfunction

  task automatic write_reg(logic idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == csfc_pkg::CfgNodeCount) node_cnt = val[csfc_pkg::CountW-1:0];
    else node_cost = val;
  endtask

  task automatic send_edge(logic present, logic [csfc_pkg::CountW-1:0] a,
                           logic [csfc_pkg::CountW-1:0] b,
                           logic [csfc_pkg::WeightW-1:0] w, logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid_i = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i = {2'b0, w, b, a};
    s_axis_tuser_i = present;
    s_axis_tlast_i = last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_forest(present, a, b, w, last);
    @(negedge clk_i);
  endtask

  // wait for every result, then let the block settle before reconfiguring
  task automatic drain();
    int guard;
    s_axis_tvalid_i = 1'b0;
    guard = 0;
    while (pending_totals.size() != 0 && guard < 100_000_000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (20) @(negedge clk_i);
  endtask

  // sink: random stalls, plus a counted hold-off when requested
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      m_axis_tready_i = 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      m_axis_tready_i = ($urandom_range(99) >= snk_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    forest_t exp_r;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_totals.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat %h", m_axis_tdata_o);
      end else begin
        exp_r = pending_totals.pop_front();
        if (m_axis_tdata_o[42:0] !== exp_r.cost || m_axis_tdata_o[53:43] !== exp_r.comps ||
            m_axis_tuser_o !== exp_r.dropped) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp cost %0d comps %0d drop %0d, got cost %0d comps %0d drop %0d",
                     exp_r.cost, exp_r.comps, exp_r.dropped, m_axis_tdata_o[42:0],
                     m_axis_tdata_o[53:43], m_axis_tuser_o);
        end
      end
    end
  end

  task automatic test_directed();
    write_reg(csfc_pkg::CfgNodeCount, 4);
    write_reg(csfc_pkg::CfgFixedCost, 100);
    send_edge(1, 1, 2, 10, 0);
    send_edge(1, 2, 3, 10, 0);
    send_edge(1, 1, 3, 5, 0);
    send_edge(1, 4, 4, 1, 0);      // self loop
    send_edge(1, 1, 4, 101, 0);    // over the cap, no flag
    send_edge(1, 0, 2, 3, 0);      // bad endpoint
    send_edge(0, 0, 0, 0, 0);      // idle item
    send_edge(1, 2, 5, 3, 1);      // bad endpoint on the finishing beat
    send_edge(0, 0, 0, 0, 1);      // finish without edges
    send_edge(1, 3, 4, 7, 0);
    send_edge(1, 1, 2, 8, 0);
    drain();
    write_reg(csfc_pkg::CfgNodeCount, 2);    // shrink mid-job
    send_edge(0, 0, 0, 0, 1);
    drain();
    write_reg(csfc_pkg::CfgNodeCount, 0);
    send_edge(1, 1, 1, 0, 1);
    drain();
    write_reg(csfc_pkg::CfgNodeCount, 2047); // clamps to the maximum
    write_reg(csfc_pkg::CfgFixedCost, 32'hFFFF_FFFF);
    send_edge(1, 1024, 1, 32'hFFFF_FFFF, 0);
    send_edge(1, 1025, 2, 32'hFFFF_FFFF, 0);
    send_edge(1, 2047, 2047, 0, 1);
    drain();
  endtask

  task automatic random_jobs(int n_items);
    int sent;
    int len;
    int n;
    logic [csfc_pkg::CountW-1:0] a;
    logic [csfc_pkg::CountW-1:0] b;
    logic [csfc_pkg::WeightW-1:0] w;
    sent = 0;
    while (sent < n_items) begin
      len = $urandom_range(1, 8);
      n = eff_nodes();
      for (int k = 0; k < len; k++) begin
        if (n > 0 && $urandom_range(9) != 0) begin
          a = $urandom_range(1, n);
          b = $urandom_range(1, n);
        end else begin
          a = $urandom_range(0, 2047);
          b = $urandom_range(0, 2047);
        end
        w = ($urandom_range(7) == 0) ? $urandom : $urandom_range(node_cost, 0);
        send_edge($urandom_range(15) != 0, a, b, w, k == len - 1);
        sent++;
      end
    end
  endtask

  task automatic test_random();
    int idle_mix[4][2] = '{'{0, 0}, '{55, 0}, '{0, 55}, '{20, 20}};
    logic [csfc_pkg::CountW-1:0] counts[6] = '{1, 2, 5, 16, 1024, 1500};
    logic [31:0] costs[4];
    for (int p = 0; p < 8; p++) begin
      costs = '{0, 1000, 32'hFFFF_FFFF, $urandom};
      src_idle_pct = idle_mix[p % 4][0];
      snk_stall_pct = idle_mix[p % 4][1];
      write_reg(csfc_pkg::CfgNodeCount, counts[$urandom_range(5)]);
      write_reg(csfc_pkg::CfgFixedCost, costs[$urandom_range(3)]);
      random_jobs(55);
      drain();
    end
    src_idle_pct = 0;
    snk_stall_pct = 0;
  endtask

  task automatic test_backpressure();
    write_reg(csfc_pkg::CfgNodeCount, 8);
    write_reg(csfc_pkg::CfgFixedCost, 500);
    hold_cycles = 5000;
    random_jobs(40);
    drain();
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);
    test_directed();
    test_random();
    test_backpressure();
    drain();
    if (errors == 0 && pending_totals.size() == 0) begin
      $display("** capped_spanning_forest_cost: PASSED **");
    end else begin
      $display("** capped_spanning_forest_cost: FAILED **");
    end
    $finish;
  end

  initial begin
    #400_000_000;
    $display("** capped_spanning_forest_cost: FAILED **");
    $finish;
  end
endmodule
